FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define RQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true out of reset.
`define RQ_ASSERT_NEVER(label, expr, msg) \
  `RQ_ASSERT(label, !(expr), msg)

`endif

FILE: design/rqmtf_pkg.sv
// ----------------------------------------------------------------------------
// rqmtf_pkg
// Shared types and constants of the round-robin move-to-front queue.
// ----------------------------------------------------------------------------
package rqmtf_pkg;

  localparam int unsigned MaxMembers = 256;
  localparam int unsigned IdW        = $clog2(MaxMembers + 1);
  localparam int unsigned AddrW      = $clog2(MaxMembers);

  typedef enum logic {
    OP_SERVE    = 1'b0,
    OP_EXPEDITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_SERVED   = 2'd0,
    ST_EXP_DONE = 2'd1,
    ST_EXP_REJ  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_SERVE,
    FSM_SEARCH
  } fsm_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [IdW-1:0]   member_id;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   served_id;
  } out_word_t;

endpackage

FILE: design/rqmtf_ram.sv
// ----------------------------------------------------------------------------
// rqmtf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rqmtf_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: design/rotating_queue_move_to_front.sv
// ----------------------------------------------------------------------------
// rotating_queue_move_to_front
// Round-robin service order of members 1..count with move-to-front expedite.
// ----------------------------------------------------------------------------
// Serve: one order-RAM read, then the result word is registered.
// Expedite: one RAM entry walked and shifted per cycle.
// Rejected expedite: result word registered in the cycle after accept.
// One word in flight; input stalls until the result word is taken.
// Reset and every member_count write start an init pass over the whole order
// RAM (order rebuilt as 1..count); input stalls during the pass.
// ----------------------------------------------------------------------------
module rotating_queue_move_to_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [8:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rqmtf_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rqmtf_pkg::out_word_t out_word_o
);

  import rqmtf_pkg::*;

  fsm_e             state_q, state_d;
  logic [IdW-1:0]   count_q, count_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] sweep_q, sweep_d;
  logic [AddrW-1:0] cur_ptr_q, cur_ptr_d;   // address of data arriving now
  logic [AddrW-1:0] nxt_ptr_q, nxt_ptr_d;   // next address to read
  logic             first_q, first_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [IdW-1:0]   prev_q, prev_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [IdW-1:0]   ram_wdata, ram_rdata;
  logic             in_acc;
  logic [IdW-1:0]   cfg_count;

  function automatic logic [AddrW-1:0] ring_inc(logic [AddrW-1:0] p, logic [IdW-1:0] c);
    logic [IdW-1:0] n;
    n = {1'b0, p} + IdW'(1);
    ring_inc = (n == c) ? '0 : n[AddrW-1:0];
  endfunction

  // Count clamp: zero taken as one, above the store depth saturated.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_count = IdW'(1);
    end else if (cfg_wdata_i > IdW'(MaxMembers)) begin
      cfg_count = IdW'(MaxMembers);
    end else begin
      cfg_count = cfg_wdata_i;
    end
  end

  assign in_stall_o = (state_q != FSM_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    sweep_d     = sweep_q;
    cur_ptr_d   = cur_ptr_q;
    nxt_ptr_d   = nxt_ptr_q;
    first_d     = first_q;
    id_d        = id_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = sweep_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    unique case (state_q)
      FSM_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = ({1'b0, sweep_q} < count_q) ? ({1'b0, sweep_q} + IdW'(1)) : '0;
        sweep_d   = sweep_q + AddrW'(1);
        if (sweep_q == AddrW'(MaxMembers - 1)) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_acc) begin
          priority if (in_word_i.opcode == OP_SERVE) begin
            ram_re    = 1'b1;
            ram_raddr = head_q;
            head_d    = ring_inc(head_q, count_q);
            state_d   = FSM_SERVE;
          end else if (in_word_i.member_id == '0 || in_word_i.member_id > count_q) begin
            out_valid_d = 1'b1;
            out_d       = '{status: ST_EXP_REJ, served_id: '0};
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_q;
            cur_ptr_d = head_q;
            nxt_ptr_d = ring_inc(head_q, count_q);
            first_d   = 1'b1;
            id_d      = in_word_i.member_id;
            state_d   = FSM_SEARCH;
          end
        end
      end
      FSM_SERVE: begin
        out_valid_d = 1'b1;
        out_d       = '{status: ST_SERVED, served_id: ram_rdata};
        state_d     = FSM_IDLE;
      end
      FSM_SEARCH: begin
        // Shift each entry back one place as the walk passes; front gets the id.
        ram_we    = 1'b1;
        ram_waddr = cur_ptr_q;
        ram_wdata = first_q ? id_q : prev_q;
        if (ram_rdata == id_q) begin
          out_valid_d = 1'b1;
          out_d       = '{status: ST_EXP_DONE, served_id: '0};
          state_d     = FSM_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = nxt_ptr_q;
          cur_ptr_d = nxt_ptr_q;
          nxt_ptr_d = ring_inc(nxt_ptr_q, count_q);
          prev_d    = ram_rdata;
          first_d   = 1'b0;
        end
      end
      default: begin
        state_d = FSM_INIT;
      end
    endcase

    if (cfg_we_i) begin
      count_d = cfg_count;
      head_d  = '0;
      sweep_d = '0;
      state_d = FSM_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_INIT;
      count_q     <= IdW'(MaxMembers);
      head_q      <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_ptr_q <= cur_ptr_d;
    nxt_ptr_q <= nxt_ptr_d;
    first_q   <= first_d;
    id_q      <= id_d;
    prev_q    <= prev_d;
    out_q     <= out_d;
  end

  rqmtf_ram #(
    .Depth (MaxMembers),
    .Width (IdW)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`include "assert_macros.svh"

  `RQ_ASSERT(a_head_in_ring, {1'b0, head_q} < count_q, "head pointer outside ring")
  `RQ_ASSERT(a_count_legal, count_q != '0 && count_q <= IdW'(MaxMembers), "count out of range")
  `RQ_ASSERT_NEVER(a_rw_same_entry, ram_we && ram_re && ram_waddr == ram_raddr, "RAM read/write collision")
  `RQ_ASSERT_NEVER(a_id_only_served, out_valid_q && out_q.status != ST_SERVED && out_q.served_id != '0, "served_id set on non-serve")

endmodule

FILE: verif/rotating_queue_move_to_front_test.sv
// ----------------------------------------------------------------------------
// rotating_queue_move_to_front_test
// Self-checking bench for the round-robin move-to-front queue: a short
// directed script, then random serve/expedite traffic across several member
// counts, each result word checked against its script row or an order model.
// ----------------------------------------------------------------------------
module rotating_queue_move_to_front_test;
  import rqmtf_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseItems = 53;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned IdMax      = (1 << IdW) - 1;
  localparam int unsigned DueDepth   = 8;

  typedef struct {
    opcode_e        op;
    logic [IdW-1:0] id;
    bit             typed;
    status_e        st;
    logic [IdW-1:0] sid;
  } script_row_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [8:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  in_word_t   in_word     = '0;
  logic       out_stall   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  out_word_t  out_word_o;

  // model of the service order
  logic [IdW-1:0] order_ring [MaxMembers];
  int unsigned    ring_head;
  int unsigned    live_count;

  // expected result words, oldest at due_rd
  out_word_t   due_buf [DueDepth];
  int unsigned due_wr    = 0;
  int unsigned due_rd    = 0;
  int unsigned fail_cnt  = 0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;

  // count 256 after reset; order starts 1, 2, 3, ...
  script_row_t script [18] = '{
    '{OP_SERVE,    9'd0,   1'b1, ST_SERVED,   9'd1},
    '{OP_SERVE,    9'd511, 1'b1, ST_SERVED,   9'd2},
    '{OP_EXPEDITE, 9'd0,   1'b1, ST_EXP_REJ,  9'd0},
    '{OP_EXPEDITE, 9'd257, 1'b1, ST_EXP_REJ,  9'd0},
    '{OP_EXPEDITE, 9'd511, 1'b1, ST_EXP_REJ,  9'd0},
    '{OP_EXPEDITE, 9'd256, 1'b1, ST_EXP_DONE, 9'd0},
    '{OP_SERVE,    9'd0,   1'b1, ST_SERVED,   9'd256},
    '{OP_EXPEDITE, 9'd3,   1'b1, ST_EXP_DONE, 9'd0},   // already at the front
    '{OP_SERVE,    9'd0,   1'b0, ST_SERVED,   9'd0},
    '{OP_EXPEDITE, 9'd1,   1'b1, ST_EXP_DONE, 9'd0},   // from near the back
    '{OP_SERVE,    9'd0,   1'b0, ST_SERVED,   9'd0},
    '{OP_EXPEDITE, 9'd170, 1'b1, ST_EXP_DONE, 9'd0},
    '{OP_EXPEDITE, 9'd85,  1'b1, ST_EXP_DONE, 9'd0},
    '{OP_SERVE,    9'd0,   1'b0, ST_SERVED,   9'd0},
    '{OP_SERVE,    9'd170, 1'b0, ST_SERVED,   9'd0},
    '{OP_EXPEDITE, 9'd4,   1'b1, ST_EXP_DONE, 9'd0},
    '{OP_SERVE,    9'd0,   1'b0, ST_SERVED,   9'd0},
    '{OP_SERVE,    9'd0,   1'b0, ST_SERVED,   9'd0}
  };

  // 0 and 300 exercise clamping, 511 is the widest write
  logic [8:0] count_plan [10] = '{9'd1, 9'd2, 9'd0, 9'd5, 9'd300,
                                  9'd3, 9'd511, 9'd17, 9'd256, 9'd9};

  rotating_queue_move_to_front DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void due_add(input out_word_t w);
    due_buf[due_wr % DueDepth] = w;
    due_wr++;
  endfunction

  function automatic out_word_t due_take();
    out_word_t w;
    w = due_buf[due_rd % DueDepth];
    due_rd++;
    return w;
  endfunction

  function automatic int unsigned due_level();
    return due_wr - due_rd;
  endfunction

  function automatic void rebuild_order(input logic [8:0] written);
    int unsigned c;
    c = written;
    if (c < 1) c = 1;
    if (c > MaxMembers) c = MaxMembers;
    live_count = c;
    ring_head  = 0;
    for (int unsigned i = 0; i < MaxMembers; i++)
      order_ring[i] = (i < c) ? IdW'(i + 1) : '0;
  endfunction

  function automatic out_word_t advance_order(input in_word_t w);
    out_word_t   r;
    int unsigned id;
    int unsigned pos;
    id          = w.member_id;
    r.status    = ST_SERVED;
    r.served_id = '0;
    if (w.opcode == OP_SERVE) begin
      r.served_id = order_ring[ring_head];
      ring_head   = (ring_head + 1) % live_count;
    end else if (id == 0 || id > live_count) begin
      r.status = ST_EXP_REJ;
    end else begin
      pos = 0;
      while (order_ring[(ring_head + pos) % live_count] != w.member_id) pos++;
      // everything ahead of the member slides back one slot
      for (int unsigned k = pos; k > 0; k--)
        order_ring[(ring_head + k) % live_count] =
          order_ring[(ring_head + k - 1) % live_count];
      order_ring[ring_head] = w.member_id;
      r.status = ST_EXP_DONE;
    end
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    pick     = $urandom_range(0, 9);
    w.opcode = ($urandom_range(0, 1) == 0) ? OP_SERVE : OP_EXPEDITE;
    if (pick < 8)
      w.member_id = IdW'($urandom_range(1, live_count));
    else if (pick == 8)
      w.member_id = ($urandom_range(0, 1) == 0) ? IdW'(live_count + 1) : '0;
    else
      w.member_id = IdW'($urandom_range(0, IdMax));
    return w;
  endfunction

  // mostly short gaps, a few long ones; no gaps while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    while (due_level() != 0) @(posedge clk_i);
  endtask

  task automatic offer_word(input in_word_t w, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_count(input logic [8:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rebuild_order(v);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  initial begin : result_check
    out_word_t   want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall) begin
        if (due_level() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result word with nothing pending: status %0d id %0d",
                     out_word_o.status, out_word_o.served_id);
        end else begin
          want = due_take();
          if (out_word_o.status !== want.status)
            flag_mismatch("status", want.status, out_word_o.status);
          if (out_word_o.served_id !== want.served_id)
            flag_mismatch("served_id", want.served_id, out_word_o.served_id);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        hold_left = pick_gap();
        if (hold_left != 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    in_word_t  w;
    out_word_t got;
    rebuild_order(9'd256);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      w.opcode    = script[i].op;
      w.member_id = script[i].id;
      offer_word(w, pick_gap());
      got = advance_order(w);
      if (script[i].typed) begin
        got.status    = script[i].st;
        got.served_id = script[i].sid;
      end
      due_add(got);
    end

    foreach (count_plan[p]) begin
      write_count(count_plan[p]);
      calm = (p == 3);
      // receiver sits on a word long enough for the input to back up
      if (p == 1) hold_req = 1'b1;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (p == 5 && n == PhaseItems / 2) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
        w = random_word();
        offer_word(w, pick_gap());
        due_add(advance_order(w));
      end
    end

    in_valid <= 1'b0;
    calm = 1'b1;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && due_level() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
